/* src/ccov_pkg.sv */
// ----------------------------------------------------------------------------
// ccov_pkg
// Shared constants, types and interface structs of the call coverage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ccov_pkg;

    // sizes of the hit set and the shadow stack
    localparam int TABLE_BITS  = 10;
    localparam int STACK_DEPTH = 1024;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int LOAD_DIV    = 2;
    localparam int SET_LIMIT   = (TABLE_SIZE + LOAD_DIV - 1) / LOAD_DIV;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    // field widths
    localparam int ADDR_W      = 64;
    localparam int CMD_W       = 2;
    localparam int SLOT_IDX_W  = 10;
    localparam int DCOUNT_W    = 10;
    localparam int DEPTH_OUT_W = 11;
    localparam int FLAG_W      = 3;
    localparam int S_TDATA_W   = ((ADDR_W + SLOT_IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((FLAG_W + DCOUNT_W + DEPTH_OUT_W + ADDR_W + 7) / 8) * 8;

    // output beat layout, lowest bit first
    localparam int OUT_INS_POS   = 0;
    localparam int OUT_PSH_POS   = 1;
    localparam int OUT_MATCH_POS = 2;
    localparam int OUT_CNT_POS   = FLAG_W;
    localparam int OUT_DEPTH_POS = OUT_CNT_POS + DCOUNT_W;
    localparam int OUT_SLOT_POS  = OUT_DEPTH_POS + DEPTH_OUT_W;

    // hash finalizer; only product bits below MIX_SHIFT + TABLE_BITS matter
    localparam logic [ADDR_W-1:0] MIX_MULT = 64'hff51afd7ed558ccd;
    localparam int MIX_SHIFT = 33;
    localparam int PROD_W    = MIX_SHIFT + TABLE_BITS;
    localparam int MUL_LO_W  = (PROD_W + 1) / 2;
    localparam int MUL_HI_W  = PROD_W - MUL_LO_W;
    localparam int LL_W      = 2 * MUL_LO_W;
    localparam logic [MUL_LO_W-1:0] MULT_LO = MIX_MULT[MUL_LO_W-1:0];
    localparam logic [MUL_HI_W-1:0] MULT_HI = MIX_MULT[PROD_W-1:MUL_LO_W];

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [TABLE_BITS-1:0] slot_t;
    typedef logic [DEPTH_W-1:0]    depth_t;
    typedef logic [SP_W-1:0]       sp_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENTRY = 2'd0,
        CMD_EXIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // hit set request and response
    typedef struct packed {
        logic                  ins;
        logic                  rd;
        addr_t                 addr;
        slot_t                 hash_idx;
        logic [SLOT_IDX_W-1:0] slot_idx;
    } set_req_t;

    typedef struct packed {
        logic  ready;
        logic  done;
        logic  inserted;
        slot_t count;
        addr_t slot_data;
    } set_rsp_t;

    // shadow stack request and response
    typedef struct packed {
        logic  push;
        logic  pop;
        addr_t addr;
    } stk_req_t;

    typedef struct packed {
        logic   done;
        logic   pushed;
        logic   matched;
        depth_t depth;
    } stk_rsp_t;

endpackage

`default_nettype wire

/* src/ccov_hash.sv */
// ----------------------------------------------------------------------------
// ccov_hash
// Two-stage xor-shift / multiply / xor-shift finalizer giving a slot index.
// ----------------------------------------------------------------------------
`default_nettype none

module ccov_hash (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire ccov_pkg::addr_t in_addr,
    output logic                out_valid,
    output ccov_pkg::slot_t     out_idx
);
    import ccov_pkg::*;

    addr_t                 y_full;
    logic [PROD_W-1:0]     y;
    logic [MUL_LO_W-1:0]   y_lo;
    logic [MUL_HI_W-1:0]   y_hi;
    logic [LL_W-1:0]       pll_reg, pll_next;
    logic [MUL_HI_W-1:0]   plh_reg, plh_next;
    logic [MUL_HI_W-1:0]   phl_reg, phl_next;
    logic [MUL_HI_W-1:0]   sum_hi;
    logic [PROD_W-1:0]     prod;
    slot_t                 idx_reg, idx_next;
    logic                  v1_reg, v2_reg;

    // first shift and split partial products
    always_comb begin
        y_full   = in_addr ^ (in_addr >> MIX_SHIFT);
        y        = y_full[PROD_W-1:0];
        y_lo     = y[MUL_LO_W-1:0];
        y_hi     = y[PROD_W-1:MUL_LO_W];
        pll_next = LL_W'(y_lo) * LL_W'(MULT_LO);
        plh_next = MUL_HI_W'(y_lo) * MULT_HI;
        phl_next = y_hi * MUL_HI_W'(MULT_LO);
    end

    // sum partial products and fold the upper shift into the index
    always_comb begin
        sum_hi   = plh_reg + phl_reg;
        prod     = PROD_W'(pll_reg) + {sum_hi, {MUL_LO_W{1'b0}}};
        idx_next = prod[TABLE_BITS-1:0] ^ prod[MIX_SHIFT +: TABLE_BITS];
    end

    always_ff @(posedge aclk) begin
        pll_reg <= pll_next;
        plh_reg <= plh_next;
        phl_reg <= phl_next;
        idx_reg <= idx_next;
    end

    // valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_idx   = idx_reg;

endmodule

`default_nettype wire

/* src/ccov_set.sv */
// ----------------------------------------------------------------------------
// ccov_set
// Hit set memory with linear probing, slot reads and a clearing pass at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ccov_set (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ccov_pkg::set_req_t req,
    output ccov_pkg::set_rsp_t      rsp
);
    import ccov_pkg::*;

    typedef enum logic [3:0] {
        SS_CLEAR = 4'b0001,
        SS_IDLE  = 4'b0010,
        SS_PROBE = 4'b0100,
        SS_READ  = 4'b1000
    } set_state_t;

    set_state_t state_reg, state_next;
    slot_t      clr_idx_reg, clr_idx_next;
    slot_t      count_reg, count_next;
    logic       done_reg, done_next;
    logic       ins_reg, ins_next;
    addr_t      slot_reg, slot_next;
    slot_t      pos_reg, pos_next;
    addr_t      addr_reg, addr_next;
    logic       rd_ok_reg, rd_ok_next;

    addr_t      hit_mem [TABLE_SIZE];
    addr_t      rd_data_reg;
    slot_t      rd_addr;
    logic       mem_we;
    slot_t      mem_waddr;
    addr_t      mem_wdata;
    logic       set_full;
    logic       idx_in_range;

    assign set_full     = (count_reg >= TABLE_BITS'(SET_LIMIT));
    assign idx_in_range = (32'(req.slot_idx) < TABLE_SIZE);

    // probe, insert, read and clear control
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        ins_next     = ins_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        addr_next    = addr_reg;
        rd_ok_next   = rd_ok_reg;
        rd_addr      = pos_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = addr_reg;
        unique case (state_reg)
            SS_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == TABLE_BITS'(TABLE_SIZE - 1)) begin
                    state_next = SS_IDLE;
                end
            end
            SS_IDLE: begin
                if (req.ins) begin
                    if (req.addr == '0 || set_full) begin
                        ins_next  = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        rd_addr    = req.hash_idx;
                        pos_next   = req.hash_idx;
                        addr_next  = req.addr;
                        state_next = SS_PROBE;
                    end
                end else if (req.rd) begin
                    rd_addr    = TABLE_BITS'(req.slot_idx);
                    rd_ok_next = idx_in_range;
                    state_next = SS_READ;
                end
            end
            SS_PROBE: begin
                if (rd_data_reg == '0) begin
                    // empty slot: claim it
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    ins_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = SS_IDLE;
                end else if (rd_data_reg == addr_reg) begin
                    ins_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = SS_IDLE;
                end else begin
                    // occupied by another address: next slot, wrapping
                    pos_next = pos_reg + 1'b1;
                    rd_addr  = pos_reg + 1'b1;
                end
            end
            SS_READ: begin
                slot_next  = rd_ok_reg ? rd_data_reg : '0;
                done_next  = 1'b1;
                state_next = SS_IDLE;
            end
            default: begin
                state_next = SS_IDLE;
            end
        endcase
    end

    // simple dual-port table, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hit_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= hit_mem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SS_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        ins_reg   <= ins_next;
        slot_reg  <= slot_next;
        pos_reg   <= pos_next;
        addr_reg  <= addr_next;
        rd_ok_reg <= rd_ok_next;
    end

    assign rsp.ready     = (state_reg != SS_CLEAR);
    assign rsp.done      = done_reg;
    assign rsp.inserted  = ins_reg;
    assign rsp.count     = count_reg;
    assign rsp.slot_data = slot_reg;

endmodule

`default_nettype wire

/* src/ccov_stack.sv */
// ----------------------------------------------------------------------------
// ccov_stack
// Shadow call stack memory with push and a top-down search on exit.
// ----------------------------------------------------------------------------
`default_nettype none

module ccov_stack (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ccov_pkg::stk_req_t req,
    output ccov_pkg::stk_rsp_t      rsp
);
    import ccov_pkg::*;

    typedef enum logic [1:0] {
        KS_IDLE = 2'b01,
        KS_SCAN = 2'b10
    } stk_state_t;

    stk_state_t state_reg, state_next;
    depth_t     depth_reg, depth_next;
    logic       done_reg, done_next;
    logic       pushed_reg, pushed_next;
    logic       matched_reg, matched_next;
    sp_t        scan_reg, scan_next;
    addr_t      addr_reg, addr_next;

    addr_t      frame_mem [STACK_DEPTH];
    addr_t      rd_data_reg;
    sp_t        rd_addr;
    logic       mem_we;
    depth_t     depth_less;

    assign depth_less = depth_reg - 1'b1;

    // push and search control
    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        done_next    = 1'b0;
        pushed_next  = pushed_reg;
        matched_next = matched_reg;
        scan_next    = scan_reg;
        addr_next    = addr_reg;
        rd_addr      = scan_reg;
        mem_we       = 1'b0;
        unique case (state_reg)
            KS_IDLE: begin
                if (req.push) begin
                    done_next    = 1'b1;
                    matched_next = 1'b0;
                    if (depth_reg < DEPTH_W'(STACK_DEPTH)) begin
                        mem_we      = 1'b1;
                        depth_next  = depth_reg + 1'b1;
                        pushed_next = 1'b1;
                    end else begin
                        pushed_next = 1'b0;
                    end
                end else if (req.pop) begin
                    pushed_next = 1'b0;
                    addr_next   = req.addr;
                    if (depth_reg == '0) begin
                        matched_next = 1'b0;
                        done_next    = 1'b1;
                    end else begin
                        rd_addr    = depth_less[SP_W-1:0];
                        scan_next  = depth_less[SP_W-1:0];
                        state_next = KS_SCAN;
                    end
                end
            end
            KS_SCAN: begin
                if (rd_data_reg == addr_reg) begin
                    // cut back to just below the matching frame
                    depth_next   = DEPTH_W'(scan_reg);
                    matched_next = 1'b1;
                    done_next    = 1'b1;
                    state_next   = KS_IDLE;
                end else if (scan_reg == '0) begin
                    matched_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = KS_IDLE;
                end else begin
                    scan_next = scan_reg - 1'b1;
                    rd_addr   = scan_reg - 1'b1;
                end
            end
            default: begin
                state_next = KS_IDLE;
            end
        endcase
    end

    // frame memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[depth_reg[SP_W-1:0]] <= req.addr;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= KS_IDLE;
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pushed_reg  <= pushed_next;
        matched_reg <= matched_next;
        scan_reg    <= scan_next;
        addr_reg    <= addr_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.pushed  = pushed_reg;
    assign rsp.matched = matched_reg;
    assign rsp.depth   = depth_reg;

endmodule

`default_nettype wire

/* src/call_coverage_tracker.sv */
// Exit compares frames from the top down, one per cycle; entry probes hit-set
// slots, one per cycle. One item at a time; the next beat can be taken in the
// cycle after the result is loaded, also while it still waits on m_tready.
// Reset (aresetn low, synchronous) clears control state, then the hit set is
// swept, all TABLE_SIZE (1024) slots, with s_tready low.
// ----------------------------------------------------------------------------
// call_coverage_tracker
// Shadow call stack plus a linear-probing hash set of distinct entry addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module call_coverage_tracker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // address [63:0], slot_index [73:64], zero fill above
    input  wire logic [ccov_pkg::S_TDATA_W-1:0]   s_tdata,
    // command [1:0]
    input  wire logic [ccov_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // inserted [0], pushed [1], exit_matched [2], distinct_count [12:3],
    // depth_now [23:13], slot_address [87:24]
    output logic [ccov_pkg::M_TDATA_W-1:0]        m_tdata
);
    import ccov_pkg::*;

    typedef enum logic [3:0] {
        TS_IDLE  = 4'b0001,
        TS_ISSUE = 4'b0010,
        TS_WAIT  = 4'b0100,
        TS_OUT   = 4'b1000
    } top_state_t;

    top_state_t            state_reg, state_next;
    cmd_t                  cmd_reg;
    addr_t                 addr_reg;
    logic [SLOT_IDX_W-1:0] sidx_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                  in_beat;
    logic                  out_load;
    logic                  finished;
    logic                  hash_valid;
    slot_t                 hash_idx;
    set_req_t              set_req;
    set_rsp_t              set_rsp;
    stk_req_t              stk_req;
    stk_rsp_t              stk_rsp;

    assign s_tready = (state_reg == TS_IDLE) && set_rsp.ready;
    assign in_beat  = s_tvalid && s_tready;

    // units
    ccov_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  ((state_reg == TS_ISSUE) && (cmd_reg == CMD_ENTRY)),
        .in_addr   (addr_reg),
        .out_valid (hash_valid),
        .out_idx   (hash_idx)
    );

    always_comb begin
        set_req.ins      = hash_valid;
        set_req.rd       = (state_reg == TS_ISSUE) && (cmd_reg == CMD_READ);
        set_req.addr     = addr_reg;
        set_req.hash_idx = hash_idx;
        set_req.slot_idx = sidx_reg;
        stk_req.push     = (state_reg == TS_ISSUE) && (cmd_reg == CMD_ENTRY);
        stk_req.pop      = (state_reg == TS_ISSUE) && (cmd_reg == CMD_EXIT);
        stk_req.addr     = addr_reg;
    end

    ccov_set u_set (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (set_req),
        .rsp     (set_rsp)
    );

    ccov_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (stk_req),
        .rsp     (stk_rsp)
    );

    // completion of the unit that owns the command
    always_comb begin
        unique case (cmd_reg)
            CMD_ENTRY, CMD_READ: finished = set_rsp.done;
            CMD_EXIT:            finished = stk_rsp.done;
            default:             finished = 1'b1;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            TS_IDLE: begin
                if (in_beat) begin
                    state_next = TS_ISSUE;
                end
            end
            TS_ISSUE: begin
                state_next = (cmd_reg == CMD_NOP) ? TS_OUT : TS_WAIT;
            end
            TS_WAIT: begin
                if (finished) begin
                    state_next = TS_OUT;
                end
            end
            TS_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = TS_IDLE;
                end
            end
            default: begin
                state_next = TS_IDLE;
            end
        endcase
    end

    // result beat assembly
    always_comb begin
        out_data_next = '0;
        out_data_next[OUT_INS_POS]   = (cmd_reg == CMD_ENTRY) && set_rsp.inserted;
        out_data_next[OUT_PSH_POS]   = (cmd_reg == CMD_ENTRY) && stk_rsp.pushed;
        out_data_next[OUT_MATCH_POS] = (cmd_reg == CMD_EXIT) && stk_rsp.matched;
        out_data_next[OUT_CNT_POS +: DCOUNT_W]      = DCOUNT_W'(set_rsp.count);
        out_data_next[OUT_DEPTH_POS +: DEPTH_OUT_W] = DEPTH_OUT_W'(stk_rsp.depth);
        out_data_next[OUT_SLOT_POS +: ADDR_W] =
            (cmd_reg == CMD_READ) ? set_rsp.slot_data : '0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TS_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // input and output payload
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            cmd_reg  <= cmd_t'(s_tuser);
            addr_reg <= s_tdata[ADDR_W-1:0];
            sidx_reg <= s_tdata[ADDR_W +: SLOT_IDX_W];
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_rsp.depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        set_rsp.count <= TABLE_BITS'(SET_LIMIT))
        else $error("hit set filled past its load limit");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == TS_OUT))
        else $error("result beat raised outside the output step");

    a_set_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        set_rsp.done |-> (state_reg == TS_WAIT))
        else $error("hit set completion while no item waits");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// call coverage tracker testbench
// Drives entry, exit, read and unused commands through the stream input and
// checks every result beat against a cycle-free predictor of the shadow call
// stack and the linear-probing hit set. Runs a directed opening, mixed call
// traffic under several idle/stall patterns, and a deep recursion that fills
// the stack and the set, with one long result-side hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccov_pkg::*;

    // result beat as packed on m_tdata, lowest field last
    typedef struct packed {
        addr_t                  slot_address;
        logic [DEPTH_OUT_W-1:0] depth_now;
        logic [DCOUNT_W-1:0]    distinct_count;
        logic                   exit_matched;
        logic                   pushed;
        logic                   inserted;
    } tracker_result_t;

    // predicted tracker state and the queue of results still owed
    class tracker_scoreboard;
        addr_t           hit_slots [TABLE_SIZE];
        int unsigned     hit_count;
        addr_t           frames [STACK_DEPTH];
        int unsigned     depth;
        tracker_result_t due_results [$];
        int unsigned     errors;
        int unsigned     checked;
        int unsigned     peak_depth;
        int unsigned     skipped_pushes;
        int unsigned     capped_entries;
        int unsigned     resyncs;
        int unsigned     missed_exits;

        function new();
            foreach (hit_slots[i]) hit_slots[i] = '0;
            foreach (frames[i]) frames[i] = '0;
            hit_count = 0;
            depth = 0;
            errors = 0;
            checked = 0;
            peak_depth = 0;
            skipped_pushes = 0;
            capped_entries = 0;
            resyncs = 0;
            missed_exits = 0;
        endfunction

        // xor-shift / multiply / xor-shift finalizer, masked to the table
        function slot_t slot_hash(addr_t a);
            bit [63:0] x;
            x = a;
            x = x ^ (x >> MIX_SHIFT);
            x = x * MIX_MULT;
            x = x ^ (x >> MIX_SHIFT);
            return x[TABLE_BITS-1:0];
        endfunction

        // open-addressing insert, refused once the set is half full
        function bit add_address(addr_t a);
            slot_t pos;
            if (a == '0) return 1'b0;
            if (hit_count * LOAD_DIV >= TABLE_SIZE) begin
                capped_entries++;
                return 1'b0;
            end
            pos = slot_hash(a);
            for (int n = 0; n < TABLE_SIZE; n++) begin
                if (hit_slots[pos] == '0) begin
                    hit_slots[pos] = a;
                    hit_count++;
                    return 1'b1;
                end
                if (hit_slots[pos] == a) return 1'b0;
                pos = pos + 1'b1;
            end
            return 1'b0;
        endfunction

        // work out the result of one accepted input beat
        function void note_command(cmd_t c, addr_t a, logic [SLOT_IDX_W-1:0] idx);
            tracker_result_t r;
            r = '0;
            case (c)
                CMD_ENTRY: begin
                    if (depth < STACK_DEPTH) begin
                        frames[depth] = a;
                        depth++;
                        r.pushed = 1'b1;
                    end else begin
                        skipped_pushes++;
                    end
                    r.inserted = add_address(a);
                end
                CMD_EXIT: begin
                    for (int i = depth; i > 0; i--) begin
                        if (frames[i-1] == a) begin
                            if (i != depth) resyncs++;
                            depth = i - 1;
                            r.exit_matched = 1'b1;
                            break;
                        end
                    end
                    if (!r.exit_matched) missed_exits++;
                end
                CMD_READ: begin
                    if (idx < TABLE_SIZE) r.slot_address = hit_slots[idx];
                end
                default: ;
            endcase
            r.distinct_count = hit_count[DCOUNT_W-1:0];
            r.depth_now = depth[DEPTH_OUT_W-1:0];
            if (depth > peak_depth) peak_depth = depth;
            due_results.push_back(r);
        endfunction

        function void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("%t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] beat);
            tracker_result_t got, want;
            got = beat;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result beat", '0, beat[63:0]);
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (got.inserted !== want.inserted)
                report_mismatch("inserted", want.inserted, got.inserted);
            if (got.pushed !== want.pushed)
                report_mismatch("pushed", want.pushed, got.pushed);
            if (got.exit_matched !== want.exit_matched)
                report_mismatch("exit_matched", want.exit_matched, got.exit_matched);
            if (got.distinct_count !== want.distinct_count)
                report_mismatch("distinct_count", want.distinct_count, got.distinct_count);
            if (got.depth_now !== want.depth_now)
                report_mismatch("depth_now", want.depth_now, got.depth_now);
            if (got.slot_address !== want.slot_address)
                report_mismatch("slot_address", want.slot_address, got.slot_address);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // address [63:0], slot_index [73:64], zero fill above
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // command [1:0]
    logic [CMD_W-1:0]       s_tuser = CMD_NOP;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    // inserted [0], pushed [1], exit_matched [2], distinct_count [12:3],
    // depth_now [23:13], slot_address [87:24]
    logic [M_TDATA_W-1:0]   m_tdata;

    tracker_scoreboard book = new();
    int unsigned send_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          dive_started = 1'b0;
    bit          sink_held = 1'b0;
    int unsigned beats_in = 0;
    addr_t       seen_addrs [$];

    call_coverage_tracker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side: random stalls, or held off during the pressure stretch
    always @(negedge aclk) begin
        m_tready <= !sink_held && ($urandom_range(99) >= sink_stall_pct);
    end

    // accept and check result beats
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
    end

    // long hold-off of the result side while commands keep coming
    initial begin
        wait (dive_started);
        @(posedge aclk);
        sink_held = 1'b1;
        repeat (400) @(posedge aclk);
        sink_held = 1'b0;
    end

    // run time limit
    initial begin
        #12ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic addr_t rand_addr();
        return {$urandom, $urandom};
    endfunction

    // entry address: fresh, reused from recent ones, or occasionally zero
    function automatic addr_t pick_entry_addr(int unsigned fresh_pct);
        addr_t a;
        int unsigned k;
        k = $urandom_range(99);
        if (k >= 97) return '0;
        if (k >= fresh_pct && seen_addrs.size() > 0)
            return seen_addrs[$urandom_range(seen_addrs.size() - 1)];
        a = rand_addr();
        seen_addrs.push_back(a);
        if (seen_addrs.size() > 48) void'(seen_addrs.pop_front());
        return a;
    endfunction

    // slot to read: random, or where a known address hashes to
    function automatic logic [SLOT_IDX_W-1:0] pick_slot();
        if ($urandom_range(1) == 0 || seen_addrs.size() == 0)
            return SLOT_IDX_W'($urandom_range(TABLE_SIZE - 1));
        return book.slot_hash(seen_addrs[$urandom_range(seen_addrs.size() - 1)]);
    endfunction

    // one input beat; called and returning at a falling edge
    task automatic send_command(cmd_t c, addr_t a, logic [SLOT_IDX_W-1:0] idx);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= S_TDATA_W'({idx, a});
        do @(posedge aclk); while (!s_tready);
        book.note_command(c, a, idx);
        beats_in++;
        @(negedge aclk);
    endtask

    // nested call traffic with resyncs, reads and some noise
    task automatic run_call_traffic(int unsigned n);
        int unsigned r, back;
        addr_t a;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_command(CMD_ENTRY, pick_entry_addr(50), SLOT_IDX_W'($urandom));
            end else if (r < 75) begin
                a = rand_addr();
                if (book.depth > 0 && r < 71) begin
                    back = 0;
                    if (r >= 66) back = $urandom_range((book.depth > 8) ? 7 : book.depth - 1);
                    a = book.frames[book.depth - 1 - back];
                end
                send_command(CMD_EXIT, a, SLOT_IDX_W'($urandom));
            end else if (r < 92) begin
                send_command(CMD_READ, rand_addr(), pick_slot());
            end else begin
                send_command(($urandom_range(1) == 0) ? CMD_NOP : CMD_EXIT, rand_addr(),
                             SLOT_IDX_W'($urandom));
            end
        end
    endtask

    // deep recursion: fill the stack past its end and the set past half
    task automatic run_deep_recursion();
        addr_t marker;
        int unsigned skips;
        marker = rand_addr();
        send_command(CMD_ENTRY, marker, '0);
        skips = 0;
        while (skips < 4) begin
            if ($urandom_range(19) == 0) begin
                send_command(CMD_READ, rand_addr(), pick_slot());
            end else begin
                if (book.depth == STACK_DEPTH) skips++;
                send_command(CMD_ENTRY, pick_entry_addr(85), SLOT_IDX_W'($urandom));
            end
        end
        // full-depth searches: a miss, a top match, then unwind to the marker
        send_command(CMD_EXIT, rand_addr(), '0);
        send_command(CMD_EXIT, book.frames[book.depth - 1], '0);
        send_command(CMD_EXIT, marker, '0);
        repeat (24) send_command(CMD_READ, rand_addr(), SLOT_IDX_W'($urandom));
    endtask

    initial begin
        // reset, then wait out the hit-set sweep through the handshake
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed opening
        send_command(CMD_READ,  '0, '0);
        send_command(CMD_READ,  '1, '1);
        send_command(CMD_ENTRY, '0, '0);
        send_command(CMD_ENTRY, '1, '1);
        send_command(CMD_ENTRY, 64'haaaa_aaaa_aaaa_aaaa, 10'h2aa);
        send_command(CMD_ENTRY, 64'h5555_5555_5555_5555, 10'h155);
        send_command(CMD_ENTRY, '1, '0);
        send_command(CMD_READ,  '0, book.slot_hash('1));
        send_command(CMD_READ,  '0, book.slot_hash(64'h5555_5555_5555_5555));
        // exit below the top frame resyncs
        send_command(CMD_EXIT,  64'h5555_5555_5555_5555, '0);
        send_command(CMD_EXIT,  64'haaaa_aaaa_aaaa_aaaa, '0);
        send_command(CMD_EXIT,  64'h0000_0000_0000_1234, '0);
        // zero-address exit matches the zero frame at the bottom
        send_command(CMD_EXIT,  '0, '0);
        send_command(CMD_EXIT,  '1, '0);
        send_command(CMD_NOP,   '1, '1);
        send_command(CMD_ENTRY, 64'h8000_0000_0000_0000, '0);
        send_command(CMD_ENTRY, 64'h0000_0000_0000_0001, '0);
        send_command(CMD_READ,  '0, book.slot_hash(64'h0000_0000_0000_0001));
        send_command(CMD_READ,  '0, book.slot_hash(64'h8000_0000_0000_0000));

        // random traffic under the idle patterns
        run_call_traffic(50);
        send_idle_pct = 55;
        run_call_traffic(50);
        send_idle_pct = 0;
        sink_stall_pct = 55;
        dive_started = 1'b1;
        run_deep_recursion();
        send_idle_pct = 7;
        sink_stall_pct = 7;
        run_call_traffic(50);
        s_tvalid <= 1'b0;

        // drain, then let any stray beat show up
        for (int n = 0; n < 5000 && book.due_results.size() != 0; n++) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (book.due_results.size() != 0) begin
            $display("%0d results never arrived", book.due_results.size());
            book.errors += book.due_results.size();
        end

        $display("%0d commands sent, %0d results checked, %0d mismatches",
                 beats_in, book.checked, book.errors);
        $display("peak stack %0d, %0d pushes skipped, %0d entries past set limit, %0d resyncs, %0d missed exits",
                 book.peak_depth, book.skipped_pushes, book.capped_entries, book.resyncs,
                 book.missed_exits);
        if (book.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
